FILE: rtl/blcc_pkg.sv
// Shared types and constants for the box/line clearance check.
`timescale 1ns / 1ps

package blcc_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned FLAGS_W    = 4;
  localparam int unsigned IN_DATA_W  = 264;  // 8 x 32 + 4, padded to bytes
  localparam int unsigned OUT_DATA_W = 104;  // 3 + 3 x 32, padded to bytes

  // line_flags bit positions
  localparam int unsigned LF_TWO_SIDED  = 0;
  localparam int unsigned LF_BLOCKING   = 1;
  localparam int unsigned LF_BLOCK_MON  = 2;
  localparam int unsigned LF_POS_SLOPE  = 3;
  localparam int unsigned SF_MISSILE    = 0;
  localparam int unsigned SF_PLAYER     = 1;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_LINE  = 1'b1
  } blcc_cmd_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] top;
  } blcc_box_t;

  typedef struct packed {
    blcc_cmd_e                 cmd;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    logic signed [COORD_W-1:0] floor_a;
    logic signed [COORD_W-1:0] ceiling_a;
    logic signed [COORD_W-1:0] floor_b;
    logic signed [COORD_W-1:0] ceiling_b;
    logic [FLAGS_W-1:0]        line_flags;
  } blcc_item_t;

  typedef struct packed {
    logic                      crossed;
    logic                      blocked;
    logic                      door_line_hit;
    logic signed [COORD_W-1:0] ceiling_z;
    logic signed [COORD_W-1:0] floor_z;
    logic signed [COORD_W-1:0] dropoff_z;
  } blcc_result_t;

endpackage

FILE: rtl/box_line_clearance_check.sv
// Top level: box/line clearance check with query state and running height limits.
`timescale 1ns / 1ps
// Path: an item is held in the input register, its result in the result register.
// Throughput: one item per cycle while the output does not stall; the side test, block
//   decision and min/max update of the running limits all sit in the single stage
//   between input and result registers.
// Ready upstream is high whenever the input register is empty or moves on this cycle.
// Reset (rst_ni low, asynchronous): pipeline empty, box, limits and mover flags zero,
//   block flag clear, so a line item before any start works against an all-zero box.

module box_line_clearance_check import blcc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16  // 8..24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: x_a, y_a, x_b, y_b, floor_a, ceiling_a, floor_b, ceiling_b, line_flags, pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: cmd
  input  logic [0:0]            s_axis_tuser_i,
  // master side
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: crossed, blocked, door_line_hit, ceiling_z, floor_z, dropoff_z, pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  blcc_item_t in_q, in_d;
  logic       out_valid_q;
  logic       advance;

  // item moves into the result register when the result slot is free or drains
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_d.cmd        = blcc_cmd_e'(s_axis_tuser_i[0]);
    in_d.x_a        = s_axis_tdata_i[31:0];
    in_d.y_a        = s_axis_tdata_i[63:32];
    in_d.x_b        = s_axis_tdata_i[95:64];
    in_d.y_b        = s_axis_tdata_i[127:96];
    in_d.floor_a    = s_axis_tdata_i[159:128];
    in_d.ceiling_a  = s_axis_tdata_i[191:160];
    in_d.floor_b    = s_axis_tdata_i[223:192];
    in_d.ceiling_b  = s_axis_tdata_i[255:224];
    in_d.line_flags = s_axis_tdata_i[259:256];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= in_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Query state
  // ---------------------------------------------------------------------------
  blcc_box_t                 box_q, box_d;
  logic signed [COORD_W-1:0] ceil_lim_q, ceil_lim_d;
  logic signed [COORD_W-1:0] floor_lim_q, floor_lim_d;
  logic signed [COORD_W-1:0] drop_lim_q, drop_lim_d;
  logic                      block_q, block_d;
  logic                      missile_q, missile_d;
  logic                      player_q, player_d;

  // ---------------------------------------------------------------------------
  // Side test
  // ---------------------------------------------------------------------------
  logic side_crossed;

  blcc_side_test #(
    .FRAC_BITS (FRAC_BITS)
  ) u_side_test (
    .box_i       (box_q),
    .lx_i        (in_q.x_a),
    .ly_i        (in_q.y_a),
    .ex_i        (in_q.x_b),
    .ey_i        (in_q.y_b),
    .pos_slope_i (in_q.line_flags[LF_POS_SLOPE]),
    .crossed_o   (side_crossed)
  );

  // ---------------------------------------------------------------------------
  // Block decision and limit update
  // ---------------------------------------------------------------------------
  blcc_result_t              res_d, res_q;
  logic                      crossed, blk, door;
  logic signed [COORD_W-1:0] top_h, bot_h, low_h;

  always_comb begin
    box_d       = box_q;
    ceil_lim_d  = ceil_lim_q;
    floor_lim_d = floor_lim_q;
    drop_lim_d  = drop_lim_q;
    block_d     = block_q;
    missile_d   = missile_q;
    player_d    = player_q;
    crossed     = 1'b0;
    blk         = 1'b0;
    door        = 1'b0;

    top_h = (in_q.ceiling_a < in_q.ceiling_b) ? in_q.ceiling_a : in_q.ceiling_b;
    bot_h = (in_q.floor_a > in_q.floor_b) ? in_q.floor_a : in_q.floor_b;
    low_h = (in_q.floor_a < in_q.floor_b) ? in_q.floor_a : in_q.floor_b;

    unique case (in_q.cmd)
      CMD_START: begin
        box_d.left   = in_q.x_a;
        box_d.bottom = in_q.y_a;
        box_d.right  = in_q.x_b;
        box_d.top    = in_q.y_b;
        floor_lim_d  = in_q.floor_a;
        drop_lim_d   = in_q.floor_a;
        ceil_lim_d   = in_q.ceiling_a;
        missile_d    = in_q.line_flags[SF_MISSILE];
        player_d     = in_q.line_flags[SF_PLAYER];
        block_d      = 1'b0;
      end
      CMD_LINE: begin
        if (!block_q) begin
          crossed = side_crossed;
          // one-sided, flagged blocking (per mover kind), or closed door
          priority if (!in_q.line_flags[LF_TWO_SIDED]) begin
            blk = 1'b1;
          end else if (!missile_q && (in_q.line_flags[LF_BLOCKING] ||
                       (!player_q && in_q.line_flags[LF_BLOCK_MON]))) begin
            blk = 1'b1;
          end else if (in_q.ceiling_a == in_q.floor_a ||
                       in_q.ceiling_b == in_q.floor_b) begin
            blk  = 1'b1;
            door = 1'b1;
          end else begin
            blk = 1'b0;
          end
          if (crossed) begin
            if (blk) begin
              block_d = 1'b1;
            end else begin
              if (top_h < ceil_lim_q)  ceil_lim_d  = top_h;
              if (bot_h > floor_lim_q) floor_lim_d = bot_h;
              if (low_h < drop_lim_q)  drop_lim_d  = low_h;
            end
          end
        end
      end
      default: ;
    endcase

    res_d.crossed       = crossed;
    res_d.blocked       = block_d;
    res_d.door_line_hit = crossed && door;
    res_d.ceiling_z     = ceil_lim_d;
    res_d.floor_z       = floor_lim_d;
    res_d.dropoff_z     = drop_lim_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q       <= '0;
      ceil_lim_q  <= '0;
      floor_lim_q <= '0;
      drop_lim_q  <= '0;
      block_q     <= 1'b0;
      missile_q   <= 1'b0;
      player_q    <= 1'b0;
    end else if (advance) begin
      box_q       <= box_d;
      ceil_lim_q  <= ceil_lim_d;
      floor_lim_q <= floor_lim_d;
      drop_lim_q  <= drop_lim_d;
      block_q     <= block_d;
      missile_q   <= missile_d;
      player_q    <= player_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, res_q.dropoff_z, res_q.floor_z, res_q.ceiling_z,
                            res_q.door_line_hit, res_q.blocked, res_q.crossed};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_door_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.door_line_hit) |-> res_q.blocked)
    else $error("door hit without block flag");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.cmd == CMD_START) |=> !block_q)
    else $error("start transfer left block flag set");

  a_floor_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.cmd == CMD_LINE) |=> (floor_lim_q >= $past(floor_lim_q)))
    else $error("floor limit dropped on a line");

  a_ceiling_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.cmd == CMD_LINE) |=> (ceil_lim_q <= $past(ceil_lim_q)))
    else $error("ceiling limit rose on a line");

  a_dropoff_below_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_lim_q <= floor_lim_q)
    else $error("dropoff above floor limit");

endmodule

FILE: rtl/blcc_side_test.sv
// Bounding-box reject and diagonal side test of one line against the mover's box.
`timescale 1ns / 1ps

module blcc_side_test import blcc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  blcc_box_t                 box_i,
  input  logic signed [COORD_W-1:0] lx_i,
  input  logic signed [COORD_W-1:0] ly_i,
  input  logic signed [COORD_W-1:0] ex_i,
  input  logic signed [COORD_W-1:0] ey_i,
  input  logic                      pos_slope_i,
  output logic                      crossed_o
);

  localparam int unsigned DiffW = COORD_W + 1;
  localparam int unsigned ShW   = DiffW - FRAC_BITS;
  localparam int unsigned ProdW = 2 * ShW;

  // full-width difference, then arithmetic shift down to integer units
  function automatic logic signed [ShW-1:0] diff_sh(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
    logic signed [DiffW-1:0] d;
    logic signed [DiffW-1:0] s;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    s = d >>> FRAC_BITS;
    return $signed(s[ShW-1:0]);
  endfunction

  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [COORD_W-1:0] x1, x2;
  logic                      overlap;
  logic signed [ShW-1:0]     ldx, ldy, dx1, dy1, dx2, dy2;
  logic signed [ProdW-1:0]   p1l, p1r, p2l, p2r;
  logic                      s1, s2;

  always_comb begin
    min_x = (lx_i < ex_i) ? lx_i : ex_i;
    max_x = (lx_i > ex_i) ? lx_i : ex_i;
    min_y = (ly_i < ey_i) ? ly_i : ey_i;
    max_y = (ly_i > ey_i) ? ly_i : ey_i;
    overlap = !(box_i.right <= min_x || box_i.left >= max_x ||
                box_i.top <= min_y || box_i.bottom >= max_y);

    // corners on the diagonal across the line's slope
    x1 = pos_slope_i ? box_i.left  : box_i.right;
    x2 = pos_slope_i ? box_i.right : box_i.left;

    ldx = diff_sh(ex_i, lx_i);
    ldy = diff_sh(ey_i, ly_i);
    dx1 = diff_sh(x1, lx_i);
    dy1 = diff_sh(box_i.top, ly_i);
    dx2 = diff_sh(x2, lx_i);
    dy2 = diff_sh(box_i.bottom, ly_i);

    p1l = ldy * dx1;
    p1r = dy1 * ldx;
    p2l = ldy * dx2;
    p2r = dy2 * ldx;
    s1  = p1l < p1r;
    s2  = p2l < p2r;

    crossed_o = overlap && (s1 != s2);
  end

endmodule

FILE: sim/blcc_checker.sv
// Checker: predicts clearance results from input transfers and compares output transfers.
`timescale 1ns / 1ps

module blcc_checker import blcc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [0:0]            s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    crossings_o,
  output int                    door_hits_o
);

  // predictor copy of the query state
  logic signed [COORD_W-1:0] box_l, box_r, box_b, box_t;
  logic signed [COORD_W-1:0] ceil_lim, floor_lim, drop_lim;
  logic                      blocked_q, is_missile, is_player;

  blcc_result_t clearance_q[$];
  blcc_result_t got, want;
  blcc_item_t   item;
  int           mismatches, results, crossings, door_hits;

  assign fail_count_o = mismatches;
  assign results_o    = results;
  assign crossings_o  = crossings;
  assign door_hits_o  = door_hits;

  task automatic report_mismatch(input string what, input longint actual, input longint wanted);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, actual, wanted);
    mismatches++;
  endtask

  // bbox reject, then diagonal side test on integer products of 16.16 differences at full width
  function automatic logic box_straddles(input longint lx, input longint ly, input longint ex,
                                         input longint ey, input logic pos);
    longint bl, br, bb, bt, x1, x2, ldx, ldy, dx1, dy1, dx2, dy2;
    bl = box_l;
    br = box_r;
    bb = box_b;
    bt = box_t;
    if (br <= ((lx < ex) ? lx : ex) || bl >= ((lx > ex) ? lx : ex) ||
        bt <= ((ly < ey) ? ly : ey) || bb >= ((ly > ey) ? ly : ey))
      return 1'b0;
    x1  = pos ? bl : br;
    x2  = pos ? br : bl;
    ldx = (ex - lx) >>> FRAC_BITS;
    ldy = (ey - ly) >>> FRAC_BITS;
    dx1 = (x1 - lx) >>> FRAC_BITS;
    dy1 = (bt - ly) >>> FRAC_BITS;
    dx2 = (x2 - lx) >>> FRAC_BITS;
    dy2 = (bb - ly) >>> FRAC_BITS;
    return (ldy * dx1 < dy1 * ldx) != (ldy * dx2 < dy2 * ldx);
  endfunction

  function automatic blcc_result_t clearance_step(input blcc_item_t it);
    blcc_result_t              r;
    logic [FLAGS_W-1:0]        fl;
    logic signed [COORD_W-1:0] fa, ca, fb, cb, hi_floor, lo_ceil, lo_floor;
    logic                      stop;
    fl              = it.line_flags;
    fa              = it.floor_a;
    ca              = it.ceiling_a;
    fb              = it.floor_b;
    cb              = it.ceiling_b;
    r.crossed       = 1'b0;
    r.door_line_hit = 1'b0;
    if (it.cmd == CMD_START) begin
      box_l      = it.x_a;
      box_b      = it.y_a;
      box_r      = it.x_b;
      box_t      = it.y_b;
      floor_lim  = fa;
      drop_lim   = fa;
      ceil_lim   = ca;
      is_missile = fl[SF_MISSILE];
      is_player  = fl[SF_PLAYER];
      blocked_q  = 1'b0;
    end else if (!blocked_q) begin
      r.crossed = box_straddles(it.x_a, it.y_a, it.x_b, it.y_b, fl[LF_POS_SLOPE]);
      if (r.crossed) begin
        stop = 1'b0;
        if (!fl[LF_TWO_SIDED]) begin
          stop = 1'b1;
        end else if (!is_missile && (fl[LF_BLOCKING] || (!is_player && fl[LF_BLOCK_MON]))) begin
          stop = 1'b1;
        end else if (ca == fa || cb == fb) begin
          stop            = 1'b1;
          r.door_line_hit = 1'b1;
        end
        if (stop) begin
          blocked_q = 1'b1;
        end else begin
          lo_ceil  = (ca < cb) ? ca : cb;
          hi_floor = (fa > fb) ? fa : fb;
          lo_floor = (fa < fb) ? fa : fb;
          if (lo_ceil < ceil_lim) ceil_lim = lo_ceil;
          if (hi_floor > floor_lim) floor_lim = hi_floor;
          if (lo_floor < drop_lim) drop_lim = lo_floor;
        end
      end
    end
    r.blocked   = blocked_q;
    r.ceiling_z = ceil_lim;
    r.floor_z   = floor_lim;
    r.dropoff_z = drop_lim;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_l      = '0;
      box_r      = '0;
      box_b      = '0;
      box_t      = '0;
      ceil_lim   = '0;
      floor_lim  = '0;
      drop_lim   = '0;
      blocked_q  = 1'b0;
      is_missile = 1'b0;
      is_player  = 1'b0;
      clearance_q.delete();
      pending_o <= 0;
    end else begin
      // output side first: a result always belongs to an older input transfer
      if (m_tvalid_i && m_tready_i) begin
        got.crossed       = m_tdata_i[0];
        got.blocked       = m_tdata_i[1];
        got.door_line_hit = m_tdata_i[2];
        got.ceiling_z     = m_tdata_i[3 +: COORD_W];
        got.floor_z       = m_tdata_i[3 + COORD_W +: COORD_W];
        got.dropoff_z     = m_tdata_i[3 + 2 * COORD_W +: COORD_W];
        results++;
        if (clearance_q.size() == 0) begin
          report_mismatch("result with nothing pending", results, 0);
        end else begin
          want = clearance_q.pop_front();
          if (got.crossed != want.crossed)
            report_mismatch("crossed", got.crossed, want.crossed);
          if (got.blocked != want.blocked)
            report_mismatch("blocked", got.blocked, want.blocked);
          if (got.door_line_hit != want.door_line_hit)
            report_mismatch("door_line_hit", got.door_line_hit, want.door_line_hit);
          if (got.ceiling_z != want.ceiling_z)
            report_mismatch("ceiling_z", got.ceiling_z, want.ceiling_z);
          if (got.floor_z != want.floor_z)
            report_mismatch("floor_z", got.floor_z, want.floor_z);
          if (got.dropoff_z != want.dropoff_z)
            report_mismatch("dropoff_z", got.dropoff_z, want.dropoff_z);
          if (want.crossed) crossings++;
          if (want.door_line_hit) door_hits++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        item.cmd        = blcc_cmd_e'(s_tuser_i[0]);
        item.x_a        = s_tdata_i[0 * COORD_W +: COORD_W];
        item.y_a        = s_tdata_i[1 * COORD_W +: COORD_W];
        item.x_b        = s_tdata_i[2 * COORD_W +: COORD_W];
        item.y_b        = s_tdata_i[3 * COORD_W +: COORD_W];
        item.floor_a    = s_tdata_i[4 * COORD_W +: COORD_W];
        item.ceiling_a  = s_tdata_i[5 * COORD_W +: COORD_W];
        item.floor_b    = s_tdata_i[6 * COORD_W +: COORD_W];
        item.ceiling_b  = s_tdata_i[7 * COORD_W +: COORD_W];
        item.line_flags = s_tdata_i[8 * COORD_W +: FLAGS_W];
        clearance_q.push_back(clearance_step(item));
      end
      pending_o <= clearance_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top: stimulus, flow control, watchdog and verdict for box_line_clearance_check.
`timescale 1ns / 1ps

module tb_top;
  import blcc_pkg::*;

  localparam int unsigned FRAC      = 16;
  localparam int          ONE       = 65536;            // 1.0 in 16.16
  localparam int          S32_MAX   = 32'sh7fff_ffff;
  localparam int          S32_MIN   = 32'sh8000_0000;
  localparam int          PHASES    = 6;
  localparam int          PHASE_LEN = 72;               // ~430 random plus directed
  localparam int          HOLD_AT   = 200;              // result count that triggers the long stall
  localparam int          HOLD_LEN  = 300;              // long output stall, in cycles
  localparam int          TAIL      = 8;                // extra clocks after the final drain
  // longest legal quiet stretch is the long stall plus a few gaps
  localparam int          WATCHDOG  = 2000;

  // line flag masks
  localparam logic [FLAGS_W-1:0] FL_TWO = FLAGS_W'(1 << LF_TWO_SIDED);
  localparam logic [FLAGS_W-1:0] FL_BLK = FLAGS_W'(1 << LF_BLOCKING);
  localparam logic [FLAGS_W-1:0] FL_MON = FLAGS_W'(1 << LF_BLOCK_MON);
  localparam logic [FLAGS_W-1:0] FL_POS = FLAGS_W'(1 << LF_POS_SLOPE);
  // mover flag masks on a start transfer
  localparam logic [FLAGS_W-1:0] MV_MISSILE = FLAGS_W'(1 << SF_MISSILE);
  localparam logic [FLAGS_W-1:0] MV_PLAYER  = FLAGS_W'(1 << SF_PLAYER);
  localparam logic [FLAGS_W-1:0] MV_MONSTER = '0;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [0:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count, pending, results, crossings, door_hits;
  int items_sent, queries_sent;
  int idle_cycles = 0;
  bit no_idle = 1'b0;   // set for phases that run both sides flat out

  // current random query, used to aim lines at the box
  int q_cx, q_cy, q_w, q_h, q_floor;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  box_line_clearance_check #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  blcc_checker #(
    .FRAC_BITS(FRAC)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .crossings_o (crossings),
    .door_hits_o (door_hits)
  );

  // tdata layout: x_a, y_a, x_b, y_b, floor_a, ceiling_a, floor_b, ceiling_b, line_flags
  function automatic logic [IN_DATA_W-1:0] pack_item(input blcc_item_t it);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[0 * COORD_W +: COORD_W] = it.x_a;
    d[1 * COORD_W +: COORD_W] = it.y_a;
    d[2 * COORD_W +: COORD_W] = it.x_b;
    d[3 * COORD_W +: COORD_W] = it.y_b;
    d[4 * COORD_W +: COORD_W] = it.floor_a;
    d[5 * COORD_W +: COORD_W] = it.ceiling_a;
    d[6 * COORD_W +: COORD_W] = it.floor_b;
    d[7 * COORD_W +: COORD_W] = it.ceiling_b;
    d[8 * COORD_W +: FLAGS_W] = it.line_flags;
    return d;
  endfunction

  function automatic blcc_item_t make_start(input int l, input int b, input int r, input int t,
                                            input int fl, input int cl,
                                            input logic [FLAGS_W-1:0] mover);
    blcc_item_t it;
    it = '0;
    it.cmd        = CMD_START;
    it.x_a        = l;
    it.y_a        = b;
    it.x_b        = r;
    it.y_b        = t;
    it.floor_a    = fl;
    it.ceiling_a  = cl;
    it.floor_b    = $urandom;   // don't-care on a start, keep it moving
    it.ceiling_b  = $urandom;
    it.line_flags = mover;
    return it;
  endfunction

  function automatic blcc_item_t make_line(input int xa, input int ya, input int xb, input int yb,
                                           input int fa, input int ca, input int fb, input int cb,
                                           input logic [FLAGS_W-1:0] fl);
    blcc_item_t it;
    it.cmd        = CMD_LINE;
    it.x_a        = xa;
    it.y_a        = ya;
    it.x_b        = xb;
    it.y_b        = yb;
    it.floor_a    = fa;
    it.ceiling_a  = ca;
    it.floor_b    = fb;
    it.ceiling_b  = cb;
    it.line_flags = fl;
    return it;
  endfunction

  // field value for noise: mostly full random, sometimes a corner value
  function automatic int noise_word();
    case ($urandom_range(0, 7))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2:       return 0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // one transfer on the input side; gap drawn per item unless a flat-out phase
  task automatic send_item(input blcc_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    s_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
    if (it.cmd == CMD_START) queries_sent++;
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic open_query();
    int l, r, b, t, swap;
    q_cx    = int'($urandom_range(0, 1 << 29)) - (1 << 28);
    q_cy    = int'($urandom_range(0, 1 << 29)) - (1 << 28);
    q_w     = int'($urandom_range(ONE / 4, 1024 * ONE));
    q_h     = int'($urandom_range(ONE / 4, 1024 * ONE));
    q_floor = (int'($urandom_range(0, 2048)) - 1024) * ONE;
    l = q_cx - q_w;
    r = q_cx + q_w;
    b = q_cy - q_h;
    t = q_cy + q_h;
    // now and then an inverted box, with left and right swapped
    if ($urandom_range(0, 15) == 0) begin
      swap = l;
      l    = r;
      r    = swap;
    end
    send_item(make_start(l, b, r, t, q_floor, q_floor + int'($urandom_range(0, 512)) * ONE,
                         FLAGS_W'($urandom_range(0, 15))));
  endtask

  // line with endpoints scattered around the current box: many cross it
  task automatic near_line();
    int xa, ya, xb, yb, fa, ca, fb, cb;
    logic [FLAGS_W-1:0] fl;
    xa = q_cx + int'($urandom_range(0, 6 * q_w)) - 3 * q_w;
    xb = q_cx + int'($urandom_range(0, 6 * q_w)) - 3 * q_w;
    ya = q_cy + int'($urandom_range(0, 6 * q_h)) - 3 * q_h;
    yb = q_cy + int'($urandom_range(0, 6 * q_h)) - 3 * q_h;
    fa = q_floor + (int'($urandom_range(0, 64)) - 32) * ONE;
    fb = q_floor + (int'($urandom_range(0, 64)) - 32) * ONE;
    ca = fa + int'($urandom_range(1, 256)) * ONE;
    cb = fb + int'($urandom_range(1, 256)) * ONE;
    if ($urandom_range(0, 7) == 0) ca = fa;     // closed door in front
    if ($urandom_range(0, 7) == 0) cb = fb;     // closed door behind
    fl = FLAGS_W'($urandom_range(0, 15));
    // lean toward passable lines so the running limits keep moving
    if ($urandom_range(0, 3) != 0) fl = fl | FL_TWO;
    if ($urandom_range(0, 2) != 0) fl = fl & ~FL_BLK;
    if ($urandom_range(0, 1) != 0) fl = fl & ~FL_MON;
    send_item(make_line(xa, ya, xb, yb, fa, ca, fb, cb, fl));
  endtask

  task automatic noise_item();
    blcc_item_t it;
    it.cmd        = blcc_cmd_e'($urandom_range(0, 1));
    it.x_a        = noise_word();
    it.y_a        = noise_word();
    it.x_b        = noise_word();
    it.y_b        = noise_word();
    it.floor_a    = noise_word();
    it.ceiling_a  = noise_word();
    it.floor_b    = noise_word();
    it.ceiling_b  = noise_word();
    it.line_flags = FLAGS_W'($urandom_range(0, 15));
    send_item(it);
  endtask

  // queries followed by a run of aimed lines, with some noise mixed in
  task automatic run_phase(input int budget, input int noise_pct);
    int sent, n_lines;
    sent = 0;
    while (sent < budget) begin
      if (int'($urandom_range(0, 99)) < noise_pct) begin
        noise_item();
        sent++;
      end else begin
        open_query();
        n_lines = $urandom_range(1, 12);
        repeat (n_lines) near_line();
        sent += n_lines + 1;
      end
    end
  endtask

  // Receiver: random ready gaps per result, one long stall so the block backs up.
  initial begin : receiver
    int gap, taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (taken == HOLD_AT) gap = HOLD_LEN;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      taken++;
    end
  end

  // Watchdog: any stretch with no transfer on either side beyond the limit ends the run.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("box_line_clearance_check test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int p;
    items_sent   = 0;
    queries_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // line before any query: runs against the all-zero box, never crosses
    send_item(make_line(-5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 0, 10 * ONE, 0, 10 * ONE, FL_TWO));
    // monster in a 20x20 box, floor 0, ceiling 128
    send_item(make_start(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 0, 128 * ONE, MV_MONSTER));
    // positive-slope crossing narrows ceiling and floor
    send_item(make_line(-20 * ONE, -5 * ONE, 20 * ONE, 5 * ONE,
                        8 * ONE, 100 * ONE, 16 * ONE, 90 * ONE, FL_TWO | FL_POS));
    // well clear of the box
    send_item(make_line(30 * ONE, 30 * ONE, 40 * ONE, 50 * ONE, 0, 1, 0, 1, FL_TWO));
    // bboxes overlap, but the line misses the corner
    send_item(make_line(5 * ONE, 20 * ONE, 20 * ONE, 5 * ONE, 0, 64 * ONE, 0, 64 * ONE, FL_TWO));
    // lowers ceiling and dropoff
    send_item(make_line(-5 * ONE, -20 * ONE, 5 * ONE, 20 * ONE,
                        -4 * ONE, 60 * ONE, 2 * ONE, 70 * ONE, FL_TWO | FL_POS));
    // block-monsters line stops a monster; the repeat after it is ignored
    send_item(make_line(-20 * ONE, 0, 20 * ONE, 0, 0, 64 * ONE, 0, 64 * ONE, FL_TWO | FL_MON));
    send_item(make_line(-20 * ONE, 0, 20 * ONE, 0, 0, 64 * ONE, 0, 64 * ONE, FL_TWO));
    // player: passes block-monsters, stopped by blocking
    send_item(make_start(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 0, 128 * ONE, MV_PLAYER));
    send_item(make_line(-20 * ONE, 0, 20 * ONE, 0, 0, 64 * ONE, 0, 64 * ONE, FL_TWO | FL_MON));
    send_item(make_line(-20 * ONE, 0, 20 * ONE, 0, 0, 64 * ONE, 0, 64 * ONE, FL_TWO | FL_BLK));
    // missile with the unused start bits set; blocking bits have no effect
    send_item(make_start(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 0, 128 * ONE,
                         MV_MISSILE | FL_MON | FL_POS));
    send_item(make_line(-20 * ONE, 0, 20 * ONE, 0, 0, 64 * ONE, 4 * ONE, 90 * ONE,
                        FL_TWO | FL_BLK | FL_MON));
    // closed door in front
    send_item(make_line(0, -20 * ONE, 0, 20 * ONE, 32 * ONE, 32 * ONE, 0, 128 * ONE, FL_TWO));
    // closed door behind
    send_item(make_start(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 0, 128 * ONE, MV_MISSILE));
    send_item(make_line(0, -20 * ONE, 0, 20 * ONE, 0, 128 * ONE, 16 * ONE, 16 * ONE, FL_TWO));
    // one-sided line stops even a missile
    send_item(make_start(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 0, 128 * ONE, MV_MISSILE));
    send_item(make_line(-20 * ONE, 0, 20 * ONE, 0, 0, 64 * ONE, 0, 64 * ONE,
                        FL_BLK | FL_MON | FL_POS));
    // full-range box and heights, corner-to-corner lines both ways
    send_item(make_start(S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, MV_MISSILE));
    send_item(make_line(S32_MIN, S32_MIN, S32_MAX, S32_MAX,
                        S32_MIN, S32_MAX, S32_MAX, S32_MIN, FL_TWO | FL_POS));
    send_item(make_line(S32_MAX, S32_MIN, S32_MIN, S32_MAX, -1, 0, 1, 2, FL_TWO));
    // inverted box: the overlap test rejects this line
    send_item(make_start(10 * ONE, 10 * ONE, -10 * ONE, -10 * ONE, 0, 128 * ONE, MV_MONSTER));
    send_item(make_line(-20 * ONE, -5 * ONE, 20 * ONE, 5 * ONE,
                        8 * ONE, 100 * ONE, 16 * ONE, 90 * ONE, FL_TWO | FL_POS));
    drain();

    // Random part: phase 1 runs without gaps, phase 3 is noise-heavy,
    // and phase 2 always ends with a full drain.
    for (p = 0; p < PHASES; p++) begin
      no_idle = (p == 1);
      run_phase(PHASE_LEN, (p == 3) ? 40 : 10);
      if (p == 2 || $urandom_range(0, 1) != 0) drain();
    end
    no_idle = 1'b0;

    drain();
    repeat (TAIL) @(posedge clk_i);

    $display("Covered %0d input transfers (%0d queries) and %0d checked results,",
             items_sent, queries_sent, results);
    $display("  with %0d crossing lines and %0d door hits, under random and long stalls.",
             crossings, door_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("box_line_clearance_check test passed");
    end else begin
      $display("box_line_clearance_check test failed");
    end
    $finish;
  end

endmodule
